>>> rtl/das_pkg.sv
package das_pkg;

   localparam int UID_W       = 56;
   localparam int UID_LEN_W   = 3;
   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int UID_SLOTS   = UID_W / 8;

   localparam int UID_BYTES_DEFAULT = 7;

   localparam logic [TIME_W-1:0] BIO_TIMEOUT_MS = 32'd5000;

   localparam logic [MS_W-1:0] UNLOCK_HOLD_RESET    = 16'd5000;
   localparam logic [MS_W-1:0] OPEN_GRACE_RESET     = 16'd3000;
   localparam logic [MS_W-1:0] TAMPER_DEBOUNCE_RESET = 16'd50;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_UID_A       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_LEN_A       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_UID_B       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_LEN_B       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIKE_HOLD_MS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_GRACE_MS     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAMPER_GAP_MS     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDS_FINGERPRINT = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_CARD    = 3'd1,
      ST_BIO     = 3'd2,
      ST_DECIDE  = 3'd3,
      ST_GRANTED = 3'd4,
      ST_DENIED  = 3'd5,
      ST_MONITOR = 3'd6,
      ST_RELOCK  = 3'd7
   } state_type;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_GRANT_CARD = 2'd1,
      EV_GRANT_BIO  = 2'd2,
      EV_DENIED     = 2'd3
   } event_type;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_UNLOCK = 2'd1;
   localparam logic [1:0] CMD_LOCK   = 2'd2;

   typedef struct packed {
      logic [UID_W-1:0]     allow_uid_a;
      logic [UID_LEN_W-1:0] allow_len_a;
      logic [UID_W-1:0]     allow_uid_b;
      logic [UID_LEN_W-1:0] allow_len_b;
      logic [MS_W-1:0]      strike_hold_ms;
      logic [MS_W-1:0]      open_grace_ms;
      logic [MS_W-1:0]      tamper_gap_ms;
      logic                 needs_fingerprint;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]    time_ms;
      logic                 card_present;
      logic [UID_W-1:0]     card_uid;
      logic [UID_LEN_W-1:0] card_uid_len;
      logic                 exit_pressed;
      logic                 finger_match;
      logic                 door_open;
      logic                 tamper_edge;
      logic [1:0]           remote_command;
   } req_type;

   typedef struct packed {
      state_type state_now;
      logic      lock_relay;
      logic      status_led;
      event_type access_event;
      logic      alert_tamper;
      logic      alert_denied;
      logic      alert_propped;
      logic      command_ack;
   } rsp_type;

endpackage

>>> rtl/das_uid_match.sv
module das_uid_match import das_pkg::*; #(
   parameter int UID_BYTES = UID_BYTES_DEFAULT
) (
   input  logic [UID_W-1:0]     uid,
   input  logic [UID_LEN_W-1:0] uid_len,
   input  logic [UID_W-1:0]     entry_uid,
   input  logic [UID_LEN_W-1:0] entry_len,
   output logic                 hit
);

   logic [UID_SLOTS-1:0] byte_ok;

   always_comb begin
      for (int i = 0; i < UID_SLOTS; i++) begin
         if ((i < UID_BYTES) && (UID_LEN_W'(i) < uid_len)) begin
            byte_ok[i] = (uid[8*i +: 8] == entry_uid[8*i +: 8]);
         end else begin
            byte_ok[i] = 1'b1;
         end
      end
      hit = (uid_len == entry_len) && (&byte_ok);
   end

endmodule

>>> rtl/das_core.sv
module das_core import das_pkg::*; #(
   parameter int UID_BYTES = UID_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   state_type            state_ff, state_in, state_cmd;
   logic [UID_W-1:0]     held_uid_ff, held_uid_in;
   logic [UID_LEN_W-1:0] held_len_ff, held_len_in;
   logic                 bio_ff, bio_in;
   logic                 grant_ff, grant_in;
   logic [TIME_W-1:0]    entered_ff, entered_in;
   logic [TIME_W-1:0]    last_tamper_ff, last_tamper_in;
   logic                 relay_ff, relay_in;
   logic                 led_ff, led_in;

   logic [TIME_W-1:0]    since_tamper;
   logic [TIME_W-1:0]    elapsed;
   logic                 tamper_hit;
   logic                 hit_a, hit_b;
   event_type            ev;
   logic                 a_denied, a_propped;

   das_uid_match #(.UID_BYTES(UID_BYTES)) u_match_a (
      .uid       (held_uid_ff),
      .uid_len   (held_len_ff),
      .entry_uid (cfg.allow_uid_a),
      .entry_len (cfg.allow_len_a),
      .hit       (hit_a)
   );

   das_uid_match #(.UID_BYTES(UID_BYTES)) u_match_b (
      .uid       (held_uid_ff),
      .uid_len   (held_len_ff),
      .entry_uid (cfg.allow_uid_b),
      .entry_len (cfg.allow_len_b),
      .hit       (hit_b)
   );

   assign since_tamper = req.time_ms - last_tamper_ff;
   assign elapsed      = req.time_ms - entered_ff;
   assign tamper_hit   = req.tamper_edge &&
                         (since_tamper > {{(TIME_W-MS_W){1'b0}}, cfg.tamper_gap_ms});

   always_comb begin
      state_in       = state_ff;
      held_uid_in    = held_uid_ff;
      held_len_in    = held_len_ff;
      bio_in         = bio_ff;
      grant_in       = grant_ff;
      entered_in     = entered_ff;
      relay_in       = relay_ff;
      led_in         = led_ff;
      last_tamper_in = tamper_hit ? req.time_ms : last_tamper_ff;
      ev             = EV_NONE;
      a_denied       = 1'b0;
      a_propped      = 1'b0;

      // remote command comes ahead of the step
      state_cmd = state_ff;
      if ((req.remote_command == CMD_UNLOCK) && (state_ff == ST_IDLE)) begin
         grant_in   = 1'b1;
         state_cmd  = ST_GRANTED;
         entered_in = req.time_ms;
      end else if (req.remote_command == CMD_LOCK) begin
         relay_in = 1'b0;
      end
      state_in = state_cmd;

      if (tamper_hit) begin
         led_in = 1'b1;
      end

      unique case (state_cmd)
         ST_IDLE: begin
            led_in = 1'b0;
            if (req.card_present) begin
               held_uid_in = req.card_uid;
               held_len_in = req.card_uid_len;
               state_in    = ST_CARD;
               entered_in  = req.time_ms;
            end
            if (req.exit_pressed) begin
               grant_in   = 1'b1;
               state_in   = ST_GRANTED;
               entered_in = req.time_ms;
            end
         end
         ST_CARD: begin
            if (!hit_a && !hit_b) begin
               state_in = ST_DENIED;
            end else if (cfg.needs_fingerprint) begin
               state_in = ST_BIO;
            end else begin
               grant_in = 1'b1;
               state_in = ST_DECIDE;
            end
            entered_in = req.time_ms;
         end
         ST_BIO: begin
            if (req.finger_match) begin
               bio_in     = 1'b1;
               grant_in   = 1'b1;
               state_in   = ST_DECIDE;
               entered_in = req.time_ms;
            end else if (elapsed > BIO_TIMEOUT_MS) begin
               grant_in   = 1'b0;
               state_in   = ST_DECIDE;
               entered_in = req.time_ms;
            end
         end
         ST_DECIDE: begin
            state_in   = grant_ff ? ST_GRANTED : ST_DENIED;
            entered_in = req.time_ms;
         end
         ST_GRANTED: begin
            relay_in   = 1'b1;
            ev         = bio_ff ? EV_GRANT_BIO : EV_GRANT_CARD;
            state_in   = ST_MONITOR;
            entered_in = req.time_ms;
            bio_in     = 1'b0;
         end
         ST_DENIED: begin
            ev         = EV_DENIED;
            a_denied   = 1'b1;
            state_in   = ST_IDLE;
            entered_in = req.time_ms;
            grant_in   = 1'b0;
            bio_in     = 1'b0;
         end
         ST_MONITOR: begin
            if (elapsed > {{(TIME_W-MS_W){1'b0}}, cfg.strike_hold_ms}) begin
               relay_in   = 1'b0;
               state_in   = ST_RELOCK;
               entered_in = req.time_ms;
            end else if (req.door_open &&
                         (elapsed > {{(TIME_W-MS_W){1'b0}}, cfg.open_grace_ms})) begin
               a_propped = 1'b1;
            end
         end
         ST_RELOCK: begin
            state_in   = ST_IDLE;
            entered_in = req.time_ms;
            grant_in   = 1'b0;
         end
      endcase

      rsp.state_now     = state_in;
      rsp.lock_relay    = relay_in;
      rsp.status_led    = led_in;
      rsp.access_event  = ev;
      rsp.alert_tamper  = tamper_hit;
      rsp.alert_denied  = a_denied;
      rsp.alert_propped = a_propped;
      rsp.command_ack   = (req.remote_command != CMD_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bio_ff         <= 1'b0;
         grant_ff       <= 1'b0;
         entered_ff     <= '0;
         last_tamper_ff <= '0;
         relay_ff       <= 1'b0;
         led_ff         <= 1'b0;
      end else if (step_en) begin
         state_ff       <= state_in;
         bio_ff         <= bio_in;
         grant_ff       <= grant_in;
         entered_ff     <= entered_in;
         last_tamper_ff <= last_tamper_in;
         relay_ff       <= relay_in;
         led_ff         <= led_in;
      end
   end

   // card buffer, no reset
   always_ff @(posedge clock) begin
      if (step_en) begin
         held_uid_ff <= held_uid_in;
         held_len_ff <= held_len_in;
      end
   end

endmodule

>>> rtl/door_access_sequencer.sv
// channel  dir  handshake            word
// req_     in   req_valid/req_ready  one poll pass: time, card, buttons, door, tamper, command
// rsp_     out  rsp_valid/rsp_ready  one pass result: state, relay, lamp, event, alerts, ack
// csr_     in   csr_write_en         register write, no wait, no read-back
//
// one pass per clock while rsp_ready allows it; a word goes from the input
// register through the core into the result register
// the input register refills while the result register waits, so a held rsp
// stalls req only once both registers are full
// reset is synchronous and brings back idle, relay released and the csr reset values
module door_access_sequencer import das_pkg::*; #(
   parameter int UID_BYTES = UID_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TIME_W-1:0]      req_time_ms,
   input  logic                   req_card_present,
   input  logic [UID_W-1:0]       req_card_uid,
   input  logic [UID_LEN_W-1:0]   req_card_uid_len,
   input  logic                   req_exit_pressed,
   input  logic                   req_finger_match,
   input  logic                   req_door_open,
   input  logic                   req_tamper_edge,
   input  logic [1:0]             req_remote_command,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_state_now,
   output logic                   rsp_lock_relay,
   output logic                   rsp_status_led,
   output logic [1:0]             rsp_access_event,
   output logic                   rsp_alert_tamper,
   output logic                   rsp_alert_denied,
   output logic                   rsp_alert_propped,
   output logic                   rsp_command_ack,

   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [UID_W-1:0]       csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    step_en;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALLOW_UID_A:       cfg_in.allow_uid_a       = csr_wdata;
            CSR_ALLOW_LEN_A:       cfg_in.allow_len_a       = csr_wdata[UID_LEN_W-1:0];
            CSR_ALLOW_UID_B:       cfg_in.allow_uid_b       = csr_wdata;
            CSR_ALLOW_LEN_B:       cfg_in.allow_len_b       = csr_wdata[UID_LEN_W-1:0];
            CSR_STRIKE_HOLD_MS:    cfg_in.strike_hold_ms    = csr_wdata[MS_W-1:0];
            CSR_OPEN_GRACE_MS:     cfg_in.open_grace_ms     = csr_wdata[MS_W-1:0];
            CSR_TAMPER_GAP_MS:     cfg_in.tamper_gap_ms     = csr_wdata[MS_W-1:0];
            CSR_NEEDS_FINGERPRINT: cfg_in.needs_fingerprint = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allow_uid_a       <= '0;
         cfg_ff.allow_len_a       <= '0;
         cfg_ff.allow_uid_b       <= '0;
         cfg_ff.allow_len_b       <= '0;
         cfg_ff.strike_hold_ms    <= UNLOCK_HOLD_RESET;
         cfg_ff.open_grace_ms     <= OPEN_GRACE_RESET;
         cfg_ff.tamper_gap_ms     <= TAMPER_DEBOUNCE_RESET;
         cfg_ff.needs_fingerprint <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign step_en      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || step_en;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = step_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      req_in.time_ms        = req_time_ms;
      req_in.card_present   = req_card_present;
      req_in.card_uid       = req_card_uid;
      req_in.card_uid_len   = req_card_uid_len;
      req_in.exit_pressed   = req_exit_pressed;
      req_in.finger_match   = req_finger_match;
      req_in.door_open      = req_door_open;
      req_in.tamper_edge    = req_tamper_edge;
      req_in.remote_command = req_remote_command;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (step_en) begin
         rsp_ff <= rsp_next;
      end
   end

   das_core #(.UID_BYTES(UID_BYTES)) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg_ff),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_now     = rsp_ff.state_now;
   assign rsp_lock_relay    = rsp_ff.lock_relay;
   assign rsp_status_led    = rsp_ff.status_led;
   assign rsp_access_event  = rsp_ff.access_event;
   assign rsp_alert_tamper  = rsp_ff.alert_tamper;
   assign rsp_alert_denied  = rsp_ff.alert_denied;
   assign rsp_alert_propped = rsp_ff.alert_propped;
   assign rsp_command_ack   = rsp_ff.command_ack;

endmodule

>>> rtl/das_checker.sv
module das_checker import das_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [2:0]             rsp_state_now,
   input logic                   rsp_lock_relay,
   input logic                   rsp_status_led,
   input logic [1:0]             rsp_access_event,
   input logic                   rsp_alert_tamper,
   input logic                   rsp_alert_denied,
   input logic                   rsp_alert_propped,
   input logic                   rsp_command_ack
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state_now) &&
         $stable(rsp_lock_relay) && $stable(rsp_status_led) &&
         $stable(rsp_access_event) && $stable(rsp_alert_tamper) &&
         $stable(rsp_alert_denied) && $stable(rsp_alert_propped) &&
         $stable(rsp_command_ack))
      else $error("stalled result word changed");

   a_idle_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_state_now == ST_IDLE) |-> !rsp_lock_relay)
      else $error("strike energised while idle");

   a_denied_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alert_denied == (rsp_access_event == EV_DENIED)))
      else $error("denied alert and denied event disagree");

   a_grant_unlocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_access_event == EV_GRANT_CARD) ||
                    (rsp_access_event == EV_GRANT_BIO))
      |-> rsp_lock_relay && (rsp_state_now == ST_MONITOR))
      else $error("grant without strike or monitor");

endmodule

bind door_access_sequencer das_checker u_das_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_state_now     (rsp_state_now),
   .rsp_lock_relay    (rsp_lock_relay),
   .rsp_status_led    (rsp_status_led),
   .rsp_access_event  (rsp_access_event),
   .rsp_alert_tamper  (rsp_alert_tamper),
   .rsp_alert_denied  (rsp_alert_denied),
   .rsp_alert_propped (rsp_alert_propped),
   .rsp_command_ack   (rsp_command_ack)
);

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import das_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_RUNS} ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TIME_W-1:0]      req_time_ms = '0;
   logic                   req_card_present = 1'b0;
   logic [UID_W-1:0]       req_card_uid = '0;
   logic [UID_LEN_W-1:0]   req_card_uid_len = '0;
   logic                   req_exit_pressed = 1'b0;
   logic                   req_finger_match = 1'b0;
   logic                   req_door_open = 1'b0;
   logic                   req_tamper_edge = 1'b0;
   logic [1:0]             req_remote_command = CMD_NONE;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_state_now;
   logic                   rsp_lock_relay;
   logic                   rsp_status_led;
   logic [1:0]             rsp_access_event;
   logic                   rsp_alert_tamper;
   logic                   rsp_alert_denied;
   logic                   rsp_alert_propped;
   logic                   rsp_command_ack;

   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ALLOW_UID_A;
   logic [UID_W-1:0]       csr_wdata = '0;

   door_access_sequencer DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the sequencer
   cfg_type           settings_now;
   state_type         door_state = ST_IDLE;
   logic [UID_W-1:0]  held_uid = '0;
   logic [2:0]        held_len = '0;
   logic              bio_ok = 1'b0;
   logic              grant_armed = 1'b0;
   logic [31:0]       entered_at = '0;
   logic [31:0]       last_tamper_at = '0;
   logic              tamper_armed = 1'b0;
   logic              relay_on = 1'b0;
   logic              lamp_on = 1'b0;

   rsp_type awaited_passes[$];
   rsp_type seen, wanted;

   int fail_count = 0;
   int passes_sent = 0;
   int passes_checked = 0;
   int settings_used = 0;
   int grants_seen = 0;
   int denials_seen = 0;
   int propped_seen = 0;
   int tampers_seen = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   logic [31:0] ms_now = 32'd1000;
   int          span_ms = 16;
   bit          door_ajar = 1'b0;

   ready_style_type ready_style = READY_ALWAYS;
   int              style_left = 0;
   int              run_left = 0;
   bit              ready_level = 1'b1;

   function automatic bit uid_listed(logic [UID_W-1:0] uid, logic [2:0] len,
                                     logic [UID_W-1:0] entry, logic [2:0] entry_len);
      logic [63:0] span;
      span = (64'd1 << (8 * len)) - 64'd1;
      return (len == entry_len) && (((uid ^ entry) & span[UID_W-1:0]) == '0);
   endfunction

   function automatic rsp_type door_pass(req_type w);
      rsp_type     r;
      logic [31:0] elapsed;
      r = '0;
      elapsed = w.time_ms - last_tamper_at;
      if (w.tamper_edge && elapsed > settings_now.tamper_gap_ms) begin
         tamper_armed = 1'b1;
         last_tamper_at = w.time_ms;
      end
      if (w.remote_command != CMD_NONE) begin
         if (w.remote_command == CMD_UNLOCK && door_state == ST_IDLE) begin
            grant_armed = 1'b1;
            door_state = ST_GRANTED;
            entered_at = w.time_ms;
         end else if (w.remote_command == CMD_LOCK) begin
            relay_on = 1'b0;
         end
         r.command_ack = 1'b1;
      end
      if (tamper_armed) begin
         tamper_armed = 1'b0;
         r.alert_tamper = 1'b1;
         lamp_on = 1'b1;
      end
      case (door_state)
         ST_IDLE: begin
            lamp_on = 1'b0;
            if (w.card_present) begin
               held_uid = w.card_uid;
               held_len = w.card_uid_len;
               door_state = ST_CARD;
               entered_at = w.time_ms;
            end
            if (w.exit_pressed) begin
               grant_armed = 1'b1;
               door_state = ST_GRANTED;
               entered_at = w.time_ms;
            end
         end
         ST_CARD: begin
            if (!uid_listed(held_uid, held_len, settings_now.allow_uid_a,
                            settings_now.allow_len_a) &&
                !uid_listed(held_uid, held_len, settings_now.allow_uid_b,
                            settings_now.allow_len_b)) begin
               door_state = ST_DENIED;
            end else if (settings_now.needs_fingerprint) begin
               door_state = ST_BIO;
            end else begin
               grant_armed = 1'b1;
               door_state = ST_DECIDE;
            end
            entered_at = w.time_ms;
         end
         ST_BIO: begin
            if (w.finger_match) begin
               bio_ok = 1'b1;
               grant_armed = 1'b1;
               door_state = ST_DECIDE;
               entered_at = w.time_ms;
            end else if (w.time_ms - entered_at > BIO_TIMEOUT_MS) begin
               grant_armed = 1'b0;
               door_state = ST_DECIDE;
               entered_at = w.time_ms;
            end
         end
         ST_DECIDE: begin
            door_state = grant_armed ? ST_GRANTED : ST_DENIED;
            entered_at = w.time_ms;
         end
         ST_GRANTED: begin
            relay_on = 1'b1;
            r.access_event = bio_ok ? EV_GRANT_BIO : EV_GRANT_CARD;
            door_state = ST_MONITOR;
            entered_at = w.time_ms;
            bio_ok = 1'b0;
         end
         ST_DENIED: begin
            r.access_event = EV_DENIED;
            r.alert_denied = 1'b1;
            door_state = ST_IDLE;
            entered_at = w.time_ms;
            grant_armed = 1'b0;
            bio_ok = 1'b0;
         end
         ST_MONITOR: begin
            elapsed = w.time_ms - entered_at;
            if (elapsed > settings_now.strike_hold_ms) begin
               relay_on = 1'b0;
               door_state = ST_RELOCK;
               entered_at = w.time_ms;
            end else if (w.door_open && elapsed > settings_now.open_grace_ms) begin
               r.alert_propped = 1'b1;
            end
         end
         default: begin
            door_state = ST_IDLE;
            entered_at = w.time_ms;
            grant_armed = 1'b0;
         end
      endcase
      r.state_now = door_state;
      r.lock_relay = relay_on;
      r.status_led = lamp_on;
      return r;
   endfunction

   function automatic string pass_text(rsp_type r);
      return $sformatf("state %0d relay %b led %b event %0d tamper %b denied %b propped %b ack %b",
                       r.state_now, r.lock_relay, r.status_led, r.access_event,
                       r.alert_tamper, r.alert_denied, r.alert_propped, r.command_ack);
   endfunction

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("error at %0t: %s", $realtime, msg);
   endtask

   // receiver: stretches of steady, random and run-length ready
   always @(posedge clock) begin
      if (style_left == 0) begin
         style_left = $urandom_range(20, 200);
         ready_style = ready_style_type'($urandom_range(0, 2));
      end
      style_left--;
      case (ready_style)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               ready_level = !ready_level;
               run_left = $urandom_range(1, 12);
            end
            run_left--;
            rsp_ready <= ready_level;
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.state_now = state_type'(rsp_state_now);
         seen.lock_relay = rsp_lock_relay;
         seen.status_led = rsp_status_led;
         seen.access_event = event_type'(rsp_access_event);
         seen.alert_tamper = rsp_alert_tamper;
         seen.alert_denied = rsp_alert_denied;
         seen.alert_propped = rsp_alert_propped;
         seen.command_ack = rsp_command_ack;
         if (awaited_passes.size() == 0) begin
            log_failure({"result word with nothing awaited: ", pass_text(seen)});
         end else begin
            wanted = awaited_passes.pop_front();
            passes_checked++;
            if (wanted.access_event == EV_GRANT_CARD || wanted.access_event == EV_GRANT_BIO)
               grants_seen++;
            if (wanted.alert_denied)
               denials_seen++;
            if (wanted.alert_propped)
               propped_seen++;
            if (wanted.alert_tamper)
               tampers_seen++;
            if (seen !== wanted)
               log_failure($sformatf("result word %0d\n   expected %s\n   actual   %s",
                                     passes_checked, pass_text(wanted), pass_text(seen)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_time_ms <= w.time_ms;
      req_card_present <= w.card_present;
      req_card_uid <= w.card_uid;
      req_card_uid_len <= w.card_uid_len;
      req_exit_pressed <= w.exit_pressed;
      req_finger_match <= w.finger_match;
      req_door_open <= w.door_open;
      req_tamper_edge <= w.tamper_edge;
      req_remote_command <= w.remote_command;
      do @(posedge clock); while (!req_ready);
      awaited_passes.push_back(door_pass(w));
      passes_sent++;
   endtask

   task automatic csr_put(logic [CSR_INDEX_W-1:0] index, logic [UID_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      req_valid <= 1'b0;
      burst_left = 0;
      while (awaited_passes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_put(CSR_ALLOW_UID_A, c.allow_uid_a);
      csr_put(CSR_ALLOW_LEN_A, UID_W'(c.allow_len_a));
      csr_put(CSR_ALLOW_UID_B, c.allow_uid_b);
      csr_put(CSR_ALLOW_LEN_B, UID_W'(c.allow_len_b));
      csr_put(CSR_STRIKE_HOLD_MS, UID_W'(c.strike_hold_ms));
      csr_put(CSR_OPEN_GRACE_MS, UID_W'(c.open_grace_ms));
      csr_put(CSR_TAMPER_GAP_MS, UID_W'(c.tamper_gap_ms));
      csr_put(CSR_NEEDS_FINGERPRINT, UID_W'(c.needs_fingerprint));
      csr_write_en <= 1'b0;
      settings_now = c;
      settings_used++;
   endtask

   function automatic req_type quiet_pass(logic [31:0] step_ms);
      req_type w;
      w = '0;
      ms_now += step_ms;
      w.time_ms = ms_now;
      return w;
   endfunction

   function automatic req_type random_pass();
      req_type          w;
      int               pick;
      logic [UID_W-1:0] noise;
      logic [UID_W-1:0] keep;
      logic [2:0]       len;
      logic [63:0]      span;
      w = '0;
      pick = $urandom_range(0, 99);
      if (pick < 2)
         ms_now = $urandom;
      else if (pick < 6)
         ms_now += $urandom_range(0, 70000);
      else if (pick < 40)
         ms_now += $urandom_range(0, 3);
      else
         ms_now += $urandom_range(0, span_ms);
      w.time_ms = ms_now;
      noise = UID_W'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) begin
         w.card_present = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            keep = settings_now.allow_uid_a;
            len = settings_now.allow_len_a;
         end else if (pick < 7) begin
            keep = settings_now.allow_uid_b;
            len = settings_now.allow_len_b;
         end else begin
            keep = UID_W'({$urandom, $urandom});
            len = UID_LEN_W'($urandom_range(0, 7));
         end
         if ($urandom_range(0, 5) == 0)
            len = UID_LEN_W'($urandom_range(0, 7));
         span = (64'd1 << (8 * len)) - 64'd1;
         w.card_uid = (keep & span[UID_W-1:0]) | (noise & ~span[UID_W-1:0]);
         w.card_uid_len = len;
      end else begin
         w.card_uid = noise;
         w.card_uid_len = UID_LEN_W'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 9) == 0)
         door_ajar = !door_ajar;
      w.door_open = ($urandom_range(0, 19) == 0) ? !door_ajar : door_ajar;
      w.exit_pressed = ($urandom_range(0, 14) == 0);
      w.finger_match = ($urandom_range(0, 2) == 0);
      w.tamper_edge = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 17)
         w.remote_command = CMD_NONE;
      else if (pick == 17)
         w.remote_command = CMD_UNLOCK;
      else if (pick == 18)
         w.remote_command = CMD_LOCK;
      else
         w.remote_command = CMD_UNKNOWN;
      return w;
   endfunction

   function automatic cfg_type random_settings(int phase);
      cfg_type c;
      if (phase == 0) begin
         c = '1;
      end else if (phase == 1) begin
         c = '0;
      end else begin
         c.allow_uid_a = UID_W'({$urandom, $urandom});
         c.allow_len_a = UID_LEN_W'($urandom_range(0, 7));
         c.allow_uid_b = UID_W'({$urandom, $urandom});
         c.allow_len_b = UID_LEN_W'($urandom_range(0, 7));
         c.strike_hold_ms = ($urandom_range(0, 4) == 0) ? MS_W'($urandom)
                                                        : MS_W'($urandom_range(0, 300));
         c.open_grace_ms = ($urandom_range(0, 4) == 0) ? MS_W'($urandom)
                                                       : MS_W'($urandom_range(0, 300));
         c.tamper_gap_ms = ($urandom_range(0, 4) == 0) ? MS_W'($urandom)
                                                       : MS_W'($urandom_range(0, 200));
         c.needs_fingerprint = 1'($urandom_range(0, 1));
      end
      return c;
   endfunction

   task automatic test_card_grant;
      cfg_type c;
      req_type w;
      c.allow_uid_a = 56'h000000EFBEADDE;
      c.allow_len_a = 3'd4;
      c.allow_uid_b = '1;
      c.allow_len_b = 3'd7;
      c.strike_hold_ms = 16'd40;
      c.open_grace_ms = 16'd10;
      c.tamper_gap_ms = 16'd50;
      c.needs_fingerprint = 1'b0;
      apply_settings(c);
      // lamp raised and dropped again by the idle step
      w = quiet_pass(1);
      w.tamper_edge = 1'b1;
      send_word(w);
      // tamper inside the debounce window, card with junk beyond its length
      w = quiet_pass(10);
      w.tamper_edge = 1'b1;
      w.card_present = 1'b1;
      w.card_uid = 56'hA5A5A5EFBEADDE;
      w.card_uid_len = 3'd4;
      send_word(w);
      send_word(quiet_pass(1));
      w = quiet_pass(1);
      w.remote_command = CMD_UNLOCK;
      send_word(w);
      send_word(quiet_pass(1));
      w = quiet_pass(20);
      w.door_open = 1'b1;
      send_word(w);
      w = quiet_pass(30);
      w.door_open = 1'b1;
      send_word(w);
      send_word(quiet_pass(1));
   endtask

   task automatic test_denied_card;
      req_type w;
      w = quiet_pass(2);
      w.card_present = 1'b1;
      w.card_uid = 56'h000000EFBEADDE;
      w.card_uid_len = 3'd3;
      send_word(w);
      send_word(quiet_pass(1));
      send_word(quiet_pass(1));
   endtask

   task automatic test_exit_and_remote;
      req_type w;
      w = quiet_pass(1);
      w.card_present = 1'b1;
      w.card_uid = '1;
      w.card_uid_len = 3'd7;
      w.exit_pressed = 1'b1;
      send_word(w);
      send_word(quiet_pass(1));
      w = quiet_pass(1);
      w.remote_command = CMD_LOCK;
      send_word(w);
      send_word(quiet_pass(41));
      w = quiet_pass(1);
      w.remote_command = CMD_UNKNOWN;
      send_word(w);
      w = quiet_pass(1);
      w.remote_command = CMD_UNLOCK;
      send_word(w);
      send_word(quiet_pass(1));
      // timestamp wraps past zero
      send_word(quiet_pass(32'hFFFF_FF00));
      send_word(quiet_pass(1));
   endtask

   task automatic test_fingerprint;
      cfg_type c;
      req_type w;
      c.allow_uid_a = '0;
      c.allow_len_a = 3'd0;
      c.allow_uid_b = '1;
      c.allow_len_b = 3'd7;
      c.strike_hold_ms = '0;
      c.open_grace_ms = '0;
      c.tamper_gap_ms = '0;
      c.needs_fingerprint = 1'b1;
      apply_settings(c);
      // zero-length card against a zero-length entry
      w = quiet_pass(1);
      w.card_present = 1'b1;
      w.card_uid = 56'h123456789ABCDE;
      w.tamper_edge = 1'b1;
      send_word(w);
      w = quiet_pass(0);
      w.tamper_edge = 1'b1;
      send_word(w);
      w = quiet_pass(1);
      w.finger_match = 1'b1;
      send_word(w);
      send_word(quiet_pass(1));
      send_word(quiet_pass(1));
      w = quiet_pass(1);
      w.door_open = 1'b1;
      send_word(w);
      send_word(quiet_pass(1));
      // no finger: wait out the biometric timeout
      w = quiet_pass(1);
      w.card_present = 1'b1;
      w.card_uid = '1;
      w.card_uid_len = 3'd7;
      send_word(w);
      send_word(quiet_pass(1));
      send_word(quiet_pass(BIO_TIMEOUT_MS));
      send_word(quiet_pass(1));
      send_word(quiet_pass(1));
      send_word(quiet_pass(1));
   endtask

   task automatic test_random_traffic;
      cfg_type c;
      for (int phase = 0; phase < 6; phase++) begin
         c = random_settings(phase);
         apply_settings(c);
         span_ms = (c.strike_hold_ms > c.open_grace_ms ? c.strike_hold_ms : c.open_grace_ms)
                   / 4 + 4;
         repeat (155) send_word(random_pass());
      end
   endtask

   initial begin
      settings_now = '0;
      settings_now.strike_hold_ms = UNLOCK_HOLD_RESET;
      settings_now.open_grace_ms = OPEN_GRACE_RESET;
      settings_now.tamper_gap_ms = TAMPER_DEBOUNCE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_card_grant();
      test_denied_card();
      test_exit_and_remote();
      test_fingerprint();
      test_random_traffic();
      req_valid <= 1'b0;
      while (awaited_passes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d poll words under %0d register settings, %0d results checked",
               passes_sent, settings_used, passes_checked);
      $display("%0d grants, %0d denials, %0d propped alerts, %0d tamper alerts, %0d errors",
               grants_seen, denials_seen, propped_seen, tampers_seen, fail_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/das_pkg.sv
rtl/das_uid_match.sv
rtl/das_core.sv
rtl/door_access_sequencer.sv
rtl/das_checker.sv
test/testbench.sv
